@@ rtl/utf8_ascii_fold_title_case_unit_macros.svh @@
// ----------------------------------------------------------------------------
// UTF-8 ASCII fold unit assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_ASCII_FOLD_TITLE_CASE_UNIT_MACROS_SVH
`define UTF8_ASCII_FOLD_TITLE_CASE_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define UATC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("uatc: property failed");

// Check that a condition never holds outside reset.
`define UATC_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("uatc: forbidden condition seen");

`endif

@@ rtl/uatc_pkg.sv @@
// ----------------------------------------------------------------------------
// UTF-8 ASCII fold package
// Decode modes, byte constants, fold table and decoder result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uatc_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_AFTER_C3 = 2'd1,
    MODE_DROP     = 2'd2
  } mode_t;

  localparam logic [7:0] LEAD_C3    = 8'hC3;
  localparam logic [1:0] CONT_TAG   = 2'b10;
  localparam logic [6:0] CHAR_QMARK = 7'h3F;
  localparam logic [6:0] CHAR_SPACE = 7'h20;
  localparam logic [6:0] CASE_BIT   = 7'h20;

  typedef struct packed {
    logic       emit;
    logic [6:0] out_char;
    logic       char_valid;
    logic       text_done;
  } dec_res_t;

  function automatic logic [6:0] fold_pair(input logic [7:0] second);
    logic [6:0] c;
    unique case (second)
      8'hA0, 8'hA1, 8'hA4: c = 7'h61;
      8'hA8, 8'hA9, 8'hAA: c = 7'h65;
      8'hAD:               c = 7'h69;
      8'hB1:               c = 7'h6E;
      8'hB3, 8'hB6:        c = 7'h6F;
      8'hBA, 8'hBC:        c = 7'h75;
      default:             c = CHAR_QMARK;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/uatc_decode.sv @@
// ----------------------------------------------------------------------------
// UTF-8 ASCII fold decoder
// Byte decode, pair fold and title-case rule for one request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uatc_decode (
  input  uatc_pkg::mode_t    mode_i,
  input  logic               cap_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output uatc_pkg::mode_t    mode_nxt_o,
  output logic               cap_nxt_o,
  output uatc_pkg::dec_res_t res_o
);
  import uatc_pkg::*;

  logic       have;
  logic [6:0] raw_char;
  logic [6:0] cased;
  logic       is_lower;
  logic       is_upper;

  // next state and raw character
  always_comb begin
    have       = 1'b0;
    raw_char   = '0;
    mode_nxt_o = MODE_NORMAL;
    unique case (mode_i)
      MODE_AFTER_C3: begin
        have     = 1'b1;
        raw_char = fold_pair(byte_i);
      end
      default: begin
        if ((mode_i == MODE_DROP) && (byte_i[7:6] == CONT_TAG)) begin
          mode_nxt_o = MODE_DROP;
        end else if (!byte_i[7]) begin
          have     = 1'b1;
          raw_char = byte_i[6:0];
        end else if ((byte_i == LEAD_C3) && !last_i) begin
          mode_nxt_o = MODE_AFTER_C3;
        end else begin
          have       = 1'b1;
          raw_char   = CHAR_QMARK;
          mode_nxt_o = MODE_DROP;
        end
      end
    endcase
    if (last_i) begin
      mode_nxt_o = MODE_NORMAL;
    end
  end

  assign is_lower = (raw_char >= 7'h61) && (raw_char <= 7'h7A);
  assign is_upper = (raw_char >= 7'h41) && (raw_char <= 7'h5A);

  // case rule and result
  always_comb begin
    cased     = raw_char;
    cap_nxt_o = cap_i;
    if (have) begin
      priority if (raw_char == CHAR_SPACE) begin
        cap_nxt_o = 1'b1;
      end else if (cap_i) begin
        cap_nxt_o = 1'b0;
        if (is_lower) begin
          cased = raw_char & ~CASE_BIT;
        end
      end else begin
        if (is_upper) begin
          cased = raw_char | CASE_BIT;
        end
      end
    end
    if (last_i) begin
      cap_nxt_o = 1'b1;
    end
    res_o.emit       = have || last_i;
    res_o.out_char   = have ? cased : 7'd0;
    res_o.char_valid = have;
    res_o.text_done  = last_i;
  end

endmodule

@@ rtl/utf8_ascii_fold_title_case_unit.sv @@
// ----------------------------------------------------------------------------
// UTF-8 ASCII fold, title case unit
// A request that is taken is held in the input register, then decoded into the result register.
// Throughput: one request per cycle; the input register and the result
// register each hold one request, so the stream stalls only on out_tready.
// Continuation bytes that are dropped, and a 0xC3 lead, give no result unless they end the text.
// Reset clears both valid flags, sets normal decode and the capital flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_ascii_fold_title_case_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // end_of_text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [6:0] out_char, [7] zero
  output logic       out_tuser,  // char_valid
  output logic       out_tlast   // text_done
);
  import uatc_pkg::*;

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  mode_t      mode_r;
  mode_t      mode_nxt;
  logic       cap_r;
  logic       cap_nxt;
  dec_res_t   res;
  logic       s1_adv;
  logic       out_valid_r;
  logic [6:0] out_char_r;
  logic       char_valid_r;
  logic       text_done_r;

  uatc_decode u_decode (
    .mode_i     (mode_r),
    .cap_i      (cap_r),
    .byte_i     (s1_byte_r),
    .last_i     (s1_last_r),
    .mode_nxt_o (mode_nxt),
    .cap_nxt_o  (cap_nxt),
    .res_o      (res)
  );

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_NORMAL;
      cap_r       <= 1'b1;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (s1_adv) begin
        mode_r      <= mode_nxt;
        cap_r       <= cap_nxt;
        out_valid_r <= res.emit;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload: hold unless advancing
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_adv && res.emit) begin
      out_char_r   <= res.out_char;
      char_valid_r <= res.char_valid;
      text_done_r  <= res.text_done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_char_r};
  assign out_tuser  = char_valid_r;
  assign out_tlast  = text_done_r;

endmodule

@@ rtl/uatc_checker.sv @@
// ----------------------------------------------------------------------------
// UTF-8 ASCII fold checker
// Port-level properties of the fold unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "utf8_ascii_fold_title_case_unit_macros.svh"

module uatc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tuser,
  input logic       out_tlast
);

  `UATC_ASSERT(a_bare_marker_is_last, clk, rst_n, (out_tvalid && !out_tuser) |-> out_tlast)
  `UATC_ASSERT(a_bare_marker_zero, clk, rst_n, (out_tvalid && !out_tuser) |-> (out_tdata == 8'd0))
  `UATC_NEVER(a_ascii_only, clk, rst_n, out_tvalid && out_tdata[7])
  `UATC_ASSERT(a_stall_holds, clk, rst_n, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))

endmodule

bind utf8_ascii_fold_title_case_unit uatc_checker u_uatc_checker (.*);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// UTF-8 ASCII fold, title case unit testbench
// Streams UTF-8 texts into the unit with random gaps on both sides and checks
// every folded character against an in-bench prediction of the decode and
// case rules: directed texts first, then random texts built from well-formed
// accented pairs, multibyte leads, stray continuation bytes and plain ASCII.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import uatc_pkg::*;

  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         RANDOM_BYTES = 1550;
  localparam logic [6:0] LOWER_A      = 7'h61;
  localparam logic [6:0] LOWER_Z      = 7'h7A;
  localparam logic [6:0] UPPER_A      = 7'h41;
  localparam logic [6:0] UPPER_Z      = 7'h5A;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic       wait_idle;
  } text_byte_t;

  typedef struct packed {
    logic [6:0] letter;
    logic       has_letter;
    logic       text_end;
  } folded_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tuser;
  logic       out_tlast;

  text_byte_t text_bytes[$];
  logic [7:0] draft[$];
  folded_t    folded_q[$];

  mode_t      fold_mode = MODE_NORMAL;
  logic       cap_next  = 1'b1;

  int         errors     = 0;
  int         cycles     = 0;
  int         gap_left   = 0;
  int         stall_left = 0;
  bit         calm_in    = 1'b0;
  bit         calm_out   = 1'b1;
  bit         nxt_valid;
  bit         nxt_ready;
  text_byte_t req;
  folded_t    want;

  int         len;
  int         pick;
  logic [7:0] second;

  utf8_ascii_fold_title_case_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [6:0] accent_base(input logic [7:0] code);
    logic [6:0] base;
    base = CHAR_QMARK;
    if (code[7:5] == 3'b101) begin
      case (code[4:0])
        5'h00, 5'h01, 5'h04: base = 7'h61;
        5'h08, 5'h09, 5'h0A: base = 7'h65;
        5'h0D:               base = 7'h69;
        5'h11:               base = 7'h6E;
        5'h13, 5'h16:        base = 7'h6F;
        5'h1A, 5'h1C:        base = 7'h75;
        default:             base = CHAR_QMARK;
      endcase
    end
    return base;
  endfunction

  task automatic fold_byte(input logic [7:0] code, input logic last);
    logic       emit;
    logic [6:0] ch;
    folded_t    res;
    emit = 1'b0;
    ch   = 7'h00;
    if (fold_mode == MODE_AFTER_C3) begin
      ch        = accent_base(code);
      emit      = 1'b1;
      fold_mode = MODE_NORMAL;
    end else if (!(fold_mode == MODE_DROP && code[7:6] == CONT_TAG)) begin
      fold_mode = MODE_NORMAL;
      if (!code[7]) begin
        ch   = code[6:0];
        emit = 1'b1;
      end else if (code == LEAD_C3 && !last) begin
        fold_mode = MODE_AFTER_C3;
      end else begin
        ch        = CHAR_QMARK;
        emit      = 1'b1;
        fold_mode = MODE_DROP;
      end
    end
    if (emit) begin
      if (ch == CHAR_SPACE) begin
        cap_next = 1'b1;
      end else if (cap_next) begin
        cap_next = 1'b0;
        if (ch >= LOWER_A && ch <= LOWER_Z) ch = ch & ~CASE_BIT;
      end else if (ch >= UPPER_A && ch <= UPPER_Z) begin
        ch = ch | CASE_BIT;
      end
    end
    if (last) begin
      fold_mode = MODE_NORMAL;
      cap_next  = 1'b1;
    end
    if (emit || last) begin
      res.letter     = ch;
      res.has_letter = emit;
      res.text_end   = last;
      folded_q.push_back(res);
    end
  endtask

  task automatic put(input logic [7:0] code);
    draft.push_back(code);
  endtask

  task automatic commit_text(input bit hold_first);
    text_byte_t tb;
    for (int i = 0; i < draft.size(); i++) begin
      tb.code      = draft[i];
      tb.last      = (i == draft.size() - 1);
      tb.wait_idle = hold_first && (i == 0);
      text_bytes.push_back(tb);
    end
    draft.delete();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        fold_byte(in_tdata, in_tlast);
        nxt_valid = 1'b0;
        if ($urandom_range(0, 99) < 3) calm_in = !calm_in;
        gap_left = calm_in ? 0 : $urandom_range(0, 18);
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (text_bytes.size() != 0 &&
                     !(text_bytes[0].wait_idle && folded_q.size() != 0)) begin
          req = text_bytes.pop_front();
          in_tdata  <= req.code;
          in_tlast  <= req.last;
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      nxt_ready = out_tready;
      if (out_tvalid && out_tready) begin
        if (folded_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: expected none, got tdata=%h tuser=%b tlast=%b",
                   $time, out_tdata, out_tuser, out_tlast);
        end else begin
          want = folded_q.pop_front();
          if (out_tdata !== {1'b0, want.letter} || out_tuser !== want.has_letter ||
              out_tlast !== want.text_end) begin
            errors++;
            $display("%0t mismatch: expected tdata=%h tuser=%b tlast=%b, got tdata=%h tuser=%b tlast=%b",
                     $time, {1'b0, want.letter}, want.has_letter, want.text_end,
                     out_tdata, out_tuser, out_tlast);
          end
        end
        nxt_ready = 1'b0;
        if ($urandom_range(0, 99) < 3) calm_out = !calm_out;
        stall_left = calm_out ? 0 : $urandom_range(0, 18);
      end
      if (!nxt_ready) begin
        if (stall_left > 0) stall_left--;
        else nxt_ready = 1'b1;
      end
      out_tready <= nxt_ready;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL utf8_ascii_fold_title_case_unit");
      $finish;
    end
  end

  initial begin
    // plain ASCII, case rule, both ends of the ASCII range
    put(8'h61); put(8'h42); put(8'h20); put(8'h7A); put(8'h7F); put(8'h00);
    commit_text(1'b0);
    // accented pairs, pair with ASCII second, pair with lead second, final lead
    put(LEAD_C3); put(8'hA9); put(LEAD_C3); put(8'h41); put(LEAD_C3); put(LEAD_C3);
    put(LEAD_C3);
    commit_text(1'b0);
    // multibyte lead with dropped tail, final dropped byte gives bare end marker
    put(8'hE2); put(8'h80); put(8'h99); put(8'h78); put(8'hFF); put(8'hBF);
    commit_text(1'b0);
    // stray continuation, lead ends drop mode, space capitalizes accented letter
    put(8'h80); put(LEAD_C3); put(8'hBC); put(8'h20); put(LEAD_C3); put(8'hA0);
    commit_text(1'b0);

    while (text_bytes.size() < 25 + RANDOM_BYTES) begin
      len = $urandom_range(1, 24);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
          put(($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25)));
        end else if (pick < 40) begin
          put(8'h20);
        end else if (pick < 50) begin
          put(8'($urandom_range(0, 127)));
        end else if (pick < 70) begin
          case ($urandom_range(0, 11))
            0:  second = 8'hA0;
            1:  second = 8'hA1;
            2:  second = 8'hA4;
            3:  second = 8'hA8;
            4:  second = 8'hA9;
            5:  second = 8'hAA;
            6:  second = 8'hAD;
            7:  second = 8'hB1;
            8:  second = 8'hB3;
            9:  second = 8'hB6;
            10: second = 8'hBA;
            default: second = 8'hBC;
          endcase
          put(LEAD_C3);
          if (pick < 65) put(second);
          else put(8'($urandom_range(0, 255)));
        end else if (pick < 85) begin
          put(8'($urandom_range(128, 255)));
          repeat ($urandom_range(0, 3)) put(8'h80 | 8'($urandom_range(0, 63)));
        end else begin
          put(8'($urandom_range(0, 255)));
        end
      end
      commit_text(text_bytes.size() == 25 || $urandom_range(0, 29) == 0);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (text_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (folded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS utf8_ascii_fold_title_case_unit");
    end else begin
      $display("FAIL utf8_ascii_fold_title_case_unit");
    end
    $finish;
  end

endmodule
